### src/ffba_pkg.sv
package ffba_pkg;

  // Field widths fixed by the request and result formats
  localparam int OP_W      = 2;
  localparam int COUNT_W   = 9;
  localparam int BLK_W     = 8;
  localparam int TOTAL_W   = 9;
  localparam int OUTCOME_W = 2;

  // Map storage: one memory row holds ROW_W block bits
  localparam int ROW_W    = 8;
  localparam int ROW_BITS = $clog2(ROW_W);

  localparam int NUM_BLOCKS_DEF = 256;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(256);

  // Request opcodes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_SET   = 2'd2;
  localparam logic [OP_W-1:0] OP_BAD   = 2'd3;

  // Result codes
  localparam logic [OUTCOME_W-1:0] OUT_DONE = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FAIL = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_BAD  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COUNT_W-1:0] count;
    logic [BLK_W-1:0]   first_block;
    logic [BLK_W-1:0]   last_block;
    logic               mark_busy;
  } req_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [BLK_W-1:0]     run_first;
    logic [BLK_W-1:0]     run_last;
  } rsp_t;

  // Control handed to the row unit for the row under work
  typedef struct packed {
    logic [ROW_W-1:0] sel;
    logic             mark_val;
  } row_op_t;

  // Row unit results
  typedef struct packed {
    logic [ROW_W-1:0]    wdata;
    logic                all_set;
    logic                found;
    logic [ROW_BITS-1:0] found_pos;
  } row_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_MARK,
    ST_RESP
  } state_t;

endpackage

### src/first_fit_block_allocator.sv
// First-fit allocator over a map of NUM_BLOCKS equal blocks, one bit per block
// (1 occupied). Requests arrive on in_valid/in_stall/in_data, one result per
// request leaves on out_valid/out_stall/out_data. A transaction happens at a
// clock edge with valid high and stall low. The user must write total_blocks
// through cfg_write/cfg_data only while no request is in flight; the block does
// not enforce this. The map lives in a memory of 8-block rows with one read and
// one write port; the block walks it one row per cycle through a shared row
// unit. An allocate scans the rows for a free run and then marks it; a free
// checks that every block in range is occupied and then clears the range; a set
// marks the range; a rejected request goes straight to its result. One request
// is in work at a time: in_stall stays high from the accept until the result is
// loaded into the output register.
// After rst the block clears the map, one row per cycle with in_stall high;
// total_blocks resets to 256.
// A stalled result holds in the output register; the next request is accepted
// meanwhile and its result waits until the output register is taken.
module first_fit_block_allocator #(
  parameter int  NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF,
  localparam int ROWS       = (NUM_BLOCKS + ffba_pkg::ROW_W - 1) / ffba_pkg::ROW_W,
  localparam int RA_W       = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ffba_pkg::req_t             in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ffba_pkg::rsp_t             out_data,
  input  logic                       cfg_write,
  input  logic [ffba_pkg::TOTAL_W-1:0] cfg_data
);
  import ffba_pkg::*;

  // Block index width and the width that holds the managed size
  localparam int BI_W  = RA_W + ROW_BITS;
  localparam int NB_W  = $clog2(NUM_BLOCKS + 1);
  localparam int SZ_W  = (NB_W > TOTAL_W) ? NB_W : TOTAL_W;

  // Registers
  state_t             state, state_next;
  logic [TOTAL_W-1:0] total_blocks;
  logic [RA_W-1:0]    rd_row, rd_row_next;
  logic               iss, iss_next;
  logic               p_valid, p_valid_next;
  logic [RA_W-1:0]    p_row;
  logic [BI_W-1:0]    lo, lo_next;
  logic [BI_W-1:0]    hi, hi_next;
  logic [COUNT_W-1:0] cnt, cnt_next;
  logic [COUNT_W-1:0] run_len, run_len_next;
  logic               mark_val, mark_val_next;
  logic [OUTCOME_W-1:0] res_code, res_code_next;
  logic               out_valid_next;
  rsp_t               out_data_next;

  // Map memory and row unit hookup
  logic               ram_we;
  logic [RA_W-1:0]    ram_waddr;
  logic [ROW_W-1:0]   ram_wdata;
  logic [ROW_W-1:0]   ram_rdata;
  row_op_t            row_op;
  row_res_t           row_res;
  logic [COUNT_W-1:0] unit_len;

  // Request decode helpers
  logic [SZ_W-1:0]    size;
  logic [BI_W-1:0]    first_idx;
  logic [BI_W-1:0]    end_idx;
  logic [BI_W-1:0]    start_idx;
  logic [RA_W-1:0]    row_lo;
  logic [RA_W-1:0]    row_hi;

  ffba_map_ram #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_row),
    .rdata(ram_rdata)
  );

  ffba_row_unit u_row (
    .data       (ram_rdata),
    .op         (row_op),
    .count      (cnt),
    .run_len_in (run_len),
    .run_len_out(unit_len),
    .res        (row_res)
  );

  // Managed size: total_blocks clamped to the map depth
  assign size = (SZ_W'(total_blocks) > SZ_W'(NUM_BLOCKS)) ? SZ_W'(NUM_BLOCKS)
                                                          : SZ_W'(total_blocks);

  assign first_idx = BI_W'(in_data.first_block);
  assign row_lo    = lo[BI_W-1:ROW_BITS];
  assign row_hi    = hi[BI_W-1:ROW_BITS];
  assign end_idx   = {p_row, row_res.found_pos};
  assign start_idx = end_idx + BI_W'(1) - BI_W'(cnt);

  // Select the blocks of the row under work that fall inside [lo, hi]
  always_comb begin
    logic [BI_W-1:0] blk;
    blk = '0;
    row_op.sel = '0;
    for (int j = 0; j < ROW_W; j++) begin
      blk = {p_row, ROW_BITS'(j)};
      row_op.sel[j] = (blk >= lo) && (blk <= hi);
    end
    row_op.mark_val = mark_val;
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      total_blocks <= TOTAL_RESET;
      rd_row       <= '0;
      iss          <= 1'b0;
      p_valid      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      rd_row    <= rd_row_next;
      iss       <= iss_next;
      p_valid   <= p_valid_next;
      out_valid <= out_valid_next;
      if (cfg_write) begin
        total_blocks <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    p_row    <= rd_row;
    lo       <= lo_next;
    hi       <= hi_next;
    cnt      <= cnt_next;
    run_len  <= run_len_next;
    mark_val <= mark_val_next;
    res_code <= res_code_next;
    out_data <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    rd_row_next    = rd_row;
    iss_next       = iss;
    p_valid_next   = iss;
    lo_next        = lo;
    hi_next        = hi;
    cnt_next       = cnt;
    run_len_next   = run_len;
    mark_val_next  = mark_val;
    res_code_next  = res_code;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    ram_we         = 1'b0;
    ram_waddr      = p_row;
    ram_wdata      = row_res.wdata;

    // Advance the read pointer through the rows of the current pass
    if (iss) begin
      if (rd_row == row_hi) begin
        iss_next = 1'b0;
      end else begin
        rd_row_next = rd_row + 1'b1;
      end
    end

    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_row;
        ram_wdata = '0;
        if (rd_row == RA_W'(ROWS - 1)) begin
          rd_row_next = '0;
          state_next  = ST_IDLE;
        end else begin
          rd_row_next = rd_row + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          cnt_next     = in_data.count;
          run_len_next = '0;
          case (in_data.op)
            OP_ALLOC: mark_val_next = 1'b1;
            OP_SET:   mark_val_next = in_data.mark_busy;
            default:  mark_val_next = 1'b0;
          endcase
          if (in_data.op == OP_ALLOC) begin
            if (in_data.count == '0) begin
              res_code_next = OUT_BAD;
              state_next    = ST_RESP;
            end else if (size == '0) begin
              res_code_next = OUT_FAIL;
              state_next    = ST_RESP;
            end else begin
              // Scan from block 0 up to the end of managed memory
              lo_next      = '0;
              hi_next      = BI_W'(size - 1'b1);
              rd_row_next  = '0;
              iss_next     = 1'b1;
              p_valid_next = 1'b0;
              state_next   = ST_SCAN;
            end
          end else if (in_data.op == OP_BAD ||
                       in_data.first_block > in_data.last_block ||
                       SZ_W'(in_data.last_block) >= size) begin
            res_code_next = OUT_BAD;
            state_next    = ST_RESP;
          end else begin
            lo_next      = first_idx;
            hi_next      = BI_W'(in_data.last_block);
            rd_row_next  = first_idx[BI_W-1:ROW_BITS];
            iss_next     = 1'b1;
            p_valid_next = 1'b0;
            state_next   = (in_data.op == OP_FREE) ? ST_CHECK : ST_MARK;
          end
        end
      end

      ST_SCAN: begin
        if (p_valid) begin
          run_len_next = unit_len;
          if (row_res.found) begin
            // Run found: mark its first count blocks occupied
            lo_next      = start_idx;
            hi_next      = end_idx;
            rd_row_next  = start_idx[BI_W-1:ROW_BITS];
            iss_next     = 1'b1;
            p_valid_next = 1'b0;
            state_next   = ST_MARK;
          end else if (p_row == row_hi) begin
            res_code_next = OUT_FAIL;
            iss_next      = 1'b0;
            p_valid_next  = 1'b0;
            state_next    = ST_RESP;
          end
        end
      end

      ST_CHECK: begin
        if (p_valid) begin
          if (!row_res.all_set) begin
            res_code_next = OUT_FAIL;
            iss_next      = 1'b0;
            p_valid_next  = 1'b0;
            state_next    = ST_RESP;
          end else if (p_row == row_hi) begin
            // Whole range occupied: go back and clear it
            rd_row_next  = row_lo;
            iss_next     = 1'b1;
            p_valid_next = 1'b0;
            state_next   = ST_MARK;
          end
        end
      end

      ST_MARK: begin
        if (p_valid) begin
          ram_we = 1'b1;
          if (p_row == row_hi) begin
            res_code_next = OUT_DONE;
            iss_next      = 1'b0;
            p_valid_next  = 1'b0;
            state_next    = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        // Load the output register once it is free or being taken
        if (!out_valid || !out_stall) begin
          out_valid_next         = 1'b1;
          out_data_next.outcome  = res_code;
          out_data_next.run_first = (res_code == OUT_DONE) ? BLK_W'(lo) : '0;
          out_data_next.run_last  = (res_code == OUT_DONE) ? BLK_W'(hi) : '0;
          state_next             = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A new result only ever comes out of the response state
  a_out_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESP)
    else $error("result raised outside the response state");

  // The map is never written while waiting for a request or a free output
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_RESP) |-> !ram_we)
    else $error("map written while idle");

  // Failed or rejected requests report a zero range
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.outcome != OUT_DONE) |->
      (out_data.run_first == '0 && out_data.run_last == '0))
    else $error("nonzero range on a failed result");

  // Row data is only consumed inside a pass
  a_pvalid_pass: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state == ST_SCAN || state == ST_CHECK || state == ST_MARK))
    else $error("row data in flight outside a pass");

endmodule

### src/ffba_map_ram.sv
module ffba_map_ram #(
  parameter int  NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF,
  localparam int ROWS       = (NUM_BLOCKS + ffba_pkg::ROW_W - 1) / ffba_pkg::ROW_W,
  localparam int RA_W       = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [RA_W-1:0]            waddr,
  input  logic [ffba_pkg::ROW_W-1:0] wdata,
  input  logic [RA_W-1:0]            raddr,
  output logic [ffba_pkg::ROW_W-1:0] rdata
);
  import ffba_pkg::*;

  logic [ROW_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/ffba_row_unit.sv
module ffba_row_unit (
  input  logic [ffba_pkg::ROW_W-1:0]   data,
  input  ffba_pkg::row_op_t            op,
  input  logic [ffba_pkg::COUNT_W-1:0] count,
  input  logic [ffba_pkg::COUNT_W-1:0] run_len_in,
  output logic [ffba_pkg::COUNT_W-1:0] run_len_out,
  output ffba_pkg::row_res_t           res
);
  import ffba_pkg::*;

  logic [COUNT_W-1:0]  len;
  logic                hit;
  logic [ROW_BITS-1:0] pos;

  // Extend the free run bit by bit; stop at the first block that completes it.
  // Blocks outside the selected range count as occupied.
  always_comb begin
    len = run_len_in;
    hit = 1'b0;
    pos = '0;
    for (int j = 0; j < ROW_W; j++) begin
      if (!hit) begin
        if (!op.sel[j] || data[j]) begin
          len = '0;
        end else begin
          len = len + 1'b1;
          if (len == count) begin
            hit = 1'b1;
            pos = ROW_BITS'(j);
          end
        end
      end
    end
  end

  assign run_len_out   = len;
  assign res.found     = hit;
  assign res.found_pos = pos;
  assign res.all_set   = &(data | ~op.sel);
  assign res.wdata     = (data & ~op.sel) | (op.sel & {ROW_W{op.mark_val}});

endmodule
